>>> src/fld_pkg.sv
// ----------------------------------------------------------------------------
// fld_pkg
// Shared types, codes and helpers of the field line deinterlacer.
// ----------------------------------------------------------------------------
package fld_pkg;

	// default line store depth
	localparam int DEF_MAX_WIDTH = 4096;
	// largest frame dimension the counters can hold
	localparam int DIM_CAP       = 4096;
	// quotient bits produced by a divider lane
	localparam int QUOT_BITS     = 8;
	localparam int STEP_CNT_W    = $clog2(QUOT_BITS + 1);

	// register reset values
	localparam logic [12:0] RST_WIDTH  = 13'd640;
	localparam logic [12:0] RST_HEIGHT = 13'd480;

	// pixel formats
	typedef enum logic [1:0] {
		FMT_GRAY  = 2'd0,
		FMT_GRAYA = 2'd1,
		FMT_RGB   = 2'd2,
		FMT_RGBA  = 2'd3
	} pix_fmt_t;

	// register map, word index
	typedef enum logic [1:0] {
		REG_PARITY = 2'd0,
		REG_WIDTH  = 2'd1,
		REG_HEIGHT = 2'd2,
		REG_FORMAT = 2'd3
	} reg_idx_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DIV,
		ST_PUT1,
		ST_PUT2
	} seq_state_t;

	// request to the rebuild unit
	typedef struct packed {
		logic        start;
		logic [31:0] up;
		logic [31:0] lo;
		logic [31:0] orig;
		pix_fmt_t    fmt;
	} rb_req_t;

	// status of the rebuild unit
	typedef struct packed {
		logic busy;
	} rb_stat_t;

	// clear the channels that a format does not use
	function automatic logic [31:0] mask_px(input logic [31:0] px, input pix_fmt_t fmt);
		logic [31:0] res;
		res = px;
		for (int k = 0; k < 4; k++) begin
			if (k > int'(fmt))
				res[8*k +: 8] = 8'd0;
		end
		return res;
	endfunction

endpackage

>>> src/fld_lane.sv
// ----------------------------------------------------------------------------
// fld_lane
// One colour lane: alpha-weighted sum, then a restoring divide by the alpha
// sum, one quotient bit per step.
// ----------------------------------------------------------------------------
module fld_lane (
	input  logic       clk,
	input  logic       load,
	input  logic       step,
	input  logic [7:0] up_b,
	input  logic [7:0] lo_b,
	input  logic [7:0] ua,
	input  logic [7:0] la,
	output logic [7:0] quot
);
	import fld_pkg::*;

	logic [16:0] num;
	logic [8:0]  rem_q;
	logic [8:0]  div_q;
	logic [7:0]  bits_q;
	logic [9:0]  trial;
	logic        qbit;

	// weighted sum of the two neighbours
	assign num = 17'(up_b * ua) + 17'(lo_b * la);

	// trial subtract of the next dividend bit
	assign trial = {rem_q, bits_q[QUOT_BITS-1]};
	assign qbit  = (trial >= {1'b0, div_q});

	// divider registers
	always_ff @(posedge clk) begin
		if (load) begin
			rem_q  <= num[16:8];
			bits_q <= num[7:0];
			div_q  <= 9'(ua) + 9'(la);
		end else if (step) begin
			rem_q  <= qbit ? 9'(trial - {1'b0, div_q}) : trial[8:0];
			bits_q <= {bits_q[QUOT_BITS-2:0], qbit};
		end
	end

	assign quot = bits_q;

endmodule

>>> src/fld_rebuild.sv
// ----------------------------------------------------------------------------
// fld_rebuild
// Rebuilds a missing pixel: three divider lanes for the colours and a merge
// stage that picks mean, weighted mean or original per channel.
// ----------------------------------------------------------------------------
module fld_rebuild (
	input  logic               clk,
	input  logic               arst_n,
	input  fld_pkg::rb_req_t   req,
	output fld_pkg::rb_stat_t  stat,
	output logic [31:0]        res
);
	import fld_pkg::*;

	logic [31:0]           up_q;
	logic [31:0]           lo_q;
	logic [31:0]           orig_q;
	pix_fmt_t              fmt_q;
	logic                  busy_q;
	logic [STEP_CNT_W-1:0] cnt_q;
	logic [7:0]            req_ua;
	logic [7:0]            req_la;
	logic [7:0]            quot [4];
	logic [7:0]            ua;
	logic [7:0]            la;
	logic [8:0]            asum;
	logic [7:0]            amean;

	// alpha of each neighbour at request time
	assign req_ua = req.up[{req.fmt, 3'b000} +: 8];
	assign req_la = req.lo[{req.fmt, 3'b000} +: 8];

	// operand capture
	always_ff @(posedge clk) begin
		if (req.start) begin
			up_q   <= req.up;
			lo_q   <= req.lo;
			orig_q <= req.orig;
			fmt_q  <= req.fmt;
		end
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_CNT_W'(QUOT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == STEP_CNT_W'(1))
				busy_q <= 1'b0;
		end
	end

	// colour lanes
	for (genvar k = 0; k < 3; k++) begin : g_lane
		fld_lane u_lane (
			.clk  (clk),
			.load (req.start),
			.step (busy_q),
			.up_b (req.up[8*k +: 8]),
			.lo_b (req.lo[8*k +: 8]),
			.ua   (req_ua),
			.la   (req_la),
			.quot (quot[k])
		);
	end
	assign quot[3] = 8'd0;

	// merge of lane results
	assign ua    = up_q[{fmt_q, 3'b000} +: 8];
	assign la    = lo_q[{fmt_q, 3'b000} +: 8];
	assign asum  = 9'(ua) + 9'(la);
	assign amean = asum[8:1];

	always_comb begin
		logic [8:0] msum;
		res = '0;
		for (int k = 0; k < 4; k++) begin
			msum = 9'(up_q[8*k +: 8]) + 9'(lo_q[8*k +: 8]);
			if (fmt_q == FMT_GRAYA || fmt_q == FMT_RGBA) begin
				if (k == int'(fmt_q))
					res[8*k +: 8] = amean;
				else if (k < int'(fmt_q))
					res[8*k +: 8] = (amean != 8'd0) ? quot[k] : orig_q[8*k +: 8];
			end else begin
				res[8*k +: 8] = msum[8:1];
			end
		end
	end

	assign stat.busy = busy_q;

endmodule

>>> src/field_line_deinterlacer.sv
// ----------------------------------------------------------------------------
// field_line_deinterlacer
// Line-average deinterlacer on a raster pixel stream with APB set-up.
// ----------------------------------------------------------------------------
// Pixels come in raster order; rows of the kept parity pass through and each
// other row is rebuilt from its kept neighbours, emitted while the next kept
// row arrives (or at once for a missing last row), each result tagged with
// row and column. One pixel is worked on at a time: a pixel of a missing row
// that is only stored returns to idle after the lookup state, a kept pixel
// with no rebuild goes to the pass-through put, and a rebuild waits for the
// 8-step restoring divider in the colour lanes, then the rebuilt result and
// any kept pixel are put out in turn, each waiting out receiver stalls. The
// two single-port line stores are read at the accepting edge. The line
// stores hold no contents after reset and need no clearing.
// Registers: keep_parity at 0x0, image_width at 0x4, image_height at 0x8,
// pixel_format at 0xC.
// ----------------------------------------------------------------------------
module field_line_deinterlacer #(
	parameter int MAX_WIDTH = fld_pkg::DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// pixel input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  chan_a,
	input  logic [7:0]  chan_b,
	input  logic [7:0]  chan_c,
	input  logic [7:0]  chan_d,
	// result output
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_a,
	output logic [7:0]  out_b,
	output logic [7:0]  out_c,
	output logic [7:0]  out_d,
	output logic [11:0] out_row,
	output logic [11:0] out_col,
	output logic        last_of_run
);
	import fld_pkg::*;

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WCAP = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;

	// configuration registers
	logic        parity_q;
	logic [12:0] width_q;
	logic [12:0] height_q;
	pix_fmt_t    fmt_q;
	logic        wr_en;
	reg_idx_t    wr_idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;
	assign wr_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parity_q <= 1'b0;
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			fmt_q    <= FMT_RGB;
		end else if (wr_en) begin
			unique case (wr_idx)
				REG_PARITY: parity_q <= pwdata[0];
				REG_WIDTH:  width_q  <= pwdata[12:0];
				REG_HEIGHT: height_q <= pwdata[12:0];
				REG_FORMAT: fmt_q    <= pix_fmt_t'(pwdata[1:0]);
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (wr_idx)
			REG_PARITY: prdata = {31'd0, parity_q};
			REG_WIDTH:  prdata = {19'd0, width_q};
			REG_HEIGHT: prdata = {19'd0, height_q};
			REG_FORMAT: prdata = {30'd0, fmt_q};
		endcase
	end

	// clamped frame dimensions
	logic [12:0] wlim;
	logic [12:0] hlim;

	always_comb begin
		wlim = width_q;
		if (wlim == 13'd0)
			wlim = 13'd1;
		if (wlim > 13'(WCAP))
			wlim = 13'(WCAP);
		hlim = height_q;
		if (hlim == 13'd0)
			hlim = 13'd1;
		if (hlim > 13'(DIM_CAP))
			hlim = 13'(DIM_CAP);
	end

	// sequencer and item state
	seq_state_t  state_q;
	seq_state_t  state_d;
	logic [11:0] col_q;
	logic [11:0] row_q;
	logic [31:0] cur_q;
	logic [11:0] item_row_q;
	logic [11:0] item_col_q;
	logic        kept_q;
	logic        use_mem_q;
	logic        need_rb_q;
	logic        in_fire;
	logic [31:0] cur;
	logic        kept;
	logic        last;
	logic [AW-1:0] idx;
	logic        out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire  = in_valid & in_ready;
	assign cur      = {chan_d, chan_c, chan_b, chan_a};
	assign kept     = (row_q[0] == parity_q);
	assign last     = (13'(row_q) + 13'd1 >= hlim);
	assign idx      = AW'(col_q);

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (13'(col_q) + 13'd1 >= wlim) begin
				col_q <= '0;
				row_q <= last ? 12'd0 : row_q + 12'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cur_q      <= cur;
			item_row_q <= row_q;
			item_col_q <= col_q;
			kept_q     <= kept;
			use_mem_q  <= kept ? (row_q >= 12'd2) : (row_q >= 12'd1);
			need_rb_q  <= kept ? (row_q >= 12'd1) : last;
		end
	end

	// line stores, read before write at the same address
	logic [31:0] upper_mem   [MAX_WIDTH];
	logic [31:0] missing_mem [MAX_WIDTH];
	logic [31:0] rd_up_s1;
	logic [31:0] rd_miss_s1;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_up_s1 <= upper_mem[idx];
			if (kept)
				upper_mem[idx] <= cur;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_miss_s1 <= missing_mem[idx];
			if (!kept && !last)
				missing_mem[idx] <= cur;
		end
	end

	// rebuild operands
	rb_req_t     rb_req;
	rb_stat_t    rb_stat;
	logic [31:0] rb_res;
	logic [31:0] up_px;

	assign up_px        = use_mem_q ? rd_up_s1 : cur_q;
	assign rb_req.start = (state_q == ST_LOOK) && need_rb_q;
	assign rb_req.up    = up_px;
	assign rb_req.lo    = kept_q ? cur_q : up_px;
	assign rb_req.orig  = kept_q ? rd_miss_s1 : cur_q;
	assign rb_req.fmt   = fmt_q;

	fld_rebuild u_rebuild (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rb_req),
		.stat   (rb_stat),
		.res    (rb_res)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state
	assign out_load = !out_valid || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire)
					state_d = ST_LOOK;
			end
			ST_LOOK: begin
				priority if (need_rb_q)
					state_d = ST_DIV;
				else if (kept_q)
					state_d = ST_PUT2;
				else
					state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (!rb_stat.busy)
					state_d = ST_PUT1;
			end
			ST_PUT1: begin
				if (out_load)
					state_d = kept_q ? ST_PUT2 : ST_IDLE;
			end
			ST_PUT2: begin
				if (out_load)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// output register
	logic        out_valid_q;
	logic [31:0] out_px_q;
	logic [11:0] out_row_q;
	logic [11:0] out_col_q;
	logic        out_last_q;
	logic        put1;
	logic        put2;

	assign put1 = (state_q == ST_PUT1) && out_load;
	assign put2 = (state_q == ST_PUT2) && out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (put1 || put2)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (put1) begin
			out_px_q   <= mask_px(rb_res, fmt_q);
			out_row_q  <= kept_q ? item_row_q - 12'd1 : item_row_q;
			out_col_q  <= item_col_q;
			out_last_q <= !kept_q;
		end else if (put2) begin
			out_px_q   <= mask_px(cur_q, fmt_q);
			out_row_q  <= item_row_q;
			out_col_q  <= item_col_q;
			out_last_q <= 1'b1;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_a       = out_px_q[7:0];
	assign out_b       = out_px_q[15:8];
	assign out_c       = out_px_q[23:16];
	assign out_d       = out_px_q[31:24];
	assign out_row     = out_row_q;
	assign out_col     = out_col_q;
	assign last_of_run = out_last_q;

	// checks
	a_idle_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !rb_stat.busy)
		else $error("rebuild unit busy while sequencer idle");

	a_accept_look: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_LOOK))
		else $error("accepted pixel not looked up");

	a_put2_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PUT2) |-> kept_q)
		else $error("pass-through result for a missing row");

	a_div_started: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && $past(state_q) == ST_LOOK) |-> rb_stat.busy)
		else $error("divide state entered without a running rebuild");

endmodule

>>> tb/field_line_deinterlacer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// field_line_deinterlacer_tb
// Self-checking bench for the line-average deinterlacer. Frames of random
// size, parity and pixel format are streamed in, with set-up written between
// frames while the block is idle. An in-bench line-average predictor builds
// the expected rebuilt and kept pixels, and a monitor checks every output
// transaction in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module field_line_deinterlacer_tb;
	import fld_pkg::*;

	localparam int LINE_DEPTH = 4096;
	localparam int IDLE_LIMIT = 3000;
	localparam int SETTLE_CYC = 40;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		logic [7:0] d;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  a;
		logic [7:0]  b;
		logic [7:0]  c;
		logic [7:0]  d;
		logic [11:0] row;
		logic [11:0] col;
		logic        last;
	} out_px_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  chan_a;
	logic [7:0]  chan_b;
	logic [7:0]  chan_c;
	logic [7:0]  chan_d;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  out_a;
	logic [7:0]  out_b;
	logic [7:0]  out_c;
	logic [7:0]  out_d;
	logic [11:0] out_row;
	logic [11:0] out_col;
	logic        last_of_run;

	// pixels waiting to be sent and output pixels still due
	pixel_t  pixel_q[$];
	out_px_t due_q[$];
	int      err_cnt = 0;
	int      sent_total;

	// shadow set-up and line stores of the predictor
	logic        sh_parity;
	logic [12:0] sh_width;
	logic [12:0] sh_height;
	pix_fmt_t    sh_fmt;
	logic [31:0] kept_line[LINE_DEPTH];
	logic [31:0] hole_line[LINE_DEPTH];
	int          col_pos = 0;
	int          row_pos = 0;

	// idling controls
	int tx_mode;
	int rx_mode;
	int rx_period;
	int rx_duty;

	field_line_deinterlacer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.chan_a      (chan_a),
		.chan_b      (chan_b),
		.chan_c      (chan_c),
		.chan_d      (chan_d),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_a       (out_a),
		.out_b       (out_b),
		.out_c       (out_c),
		.out_d       (out_d),
		.out_row     (out_row),
		.out_col     (out_col),
		.last_of_run (last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		err_cnt++;
	endtask

	// line-average blend of two neighbours, alpha weighted where present
	function automatic logic [31:0] blend_px(input logic [31:0] up, input logic [31:0] lo,
			input logic [31:0] orig);
		logic [31:0] res;
		int f;
		int ua;
		int la;
		int sum;
		int al;
		int v;
		res = '0;
		f = int'(sh_fmt);
		if (sh_fmt == FMT_GRAYA || sh_fmt == FMT_RGBA) begin
			ua = up[8*f +: 8];
			la = lo[8*f +: 8];
			sum = ua + la;
			al = sum / 2;
			for (int k = 0; k < f; k++) begin
				if (al != 0)
					v = (int'(up[8*k +: 8]) * ua + int'(lo[8*k +: 8]) * la) / sum;
				else
					v = orig[8*k +: 8];
				res[8*k +: 8] = v[7:0];
			end
			res[8*f +: 8] = al[7:0];
		end else begin
			for (int k = 0; k <= f; k++) begin
				v = (int'(up[8*k +: 8]) + int'(lo[8*k +: 8])) / 2;
				res[8*k +: 8] = v[7:0];
			end
		end
		return res;
	endfunction

	task automatic push_due(input logic [31:0] px, input int row, input int col);
		out_px_t o;
		o.a = px[7:0];
		o.b = (int'(sh_fmt) >= 1) ? px[15:8] : 8'd0;
		o.c = (int'(sh_fmt) >= 2) ? px[23:16] : 8'd0;
		o.d = (int'(sh_fmt) >= 3) ? px[31:24] : 8'd0;
		o.row = row[11:0];
		o.col = col[11:0];
		o.last = 1'b0;
		due_q.push_back(o);
	endtask

	// work out the output pixels of one accepted input pixel
	task automatic deinterlace_px(input pixel_t p);
		logic [31:0] cur;
		logic [31:0] up;
		int w;
		int h;
		int n0;
		bit kept;
		bit last_row;
		w = sh_width;
		h = sh_height;
		if (w < 1) w = 1;
		if (w > LINE_DEPTH) w = LINE_DEPTH;
		if (h < 1) h = 1;
		if (h > DIM_CAP) h = DIM_CAP;
		cur = {p.d, p.c, p.b, p.a};
		kept = (row_pos % 2) == int'(sh_parity);
		last_row = row_pos + 1 >= h;
		n0 = due_q.size();
		if (kept) begin
			if (row_pos >= 1) begin
				up = (row_pos >= 2) ? kept_line[col_pos] : cur;
				push_due(blend_px(up, cur, hole_line[col_pos]), row_pos - 1, col_pos);
			end
			push_due(cur, row_pos, col_pos);
			kept_line[col_pos] = cur;
		end else if (last_row) begin
			up = (row_pos >= 1) ? kept_line[col_pos] : cur;
			push_due(blend_px(up, up, cur), row_pos, col_pos);
		end else begin
			hole_line[col_pos] = cur;
		end
		if (due_q.size() > n0)
			due_q[due_q.size() - 1].last = 1'b1;
		if (col_pos + 1 >= w) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endtask

	// sender: bursts of random length with random gaps
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		bit v;
		pixel_t p;
		if (!arst_n) begin
			in_valid <= 1'b0;
			chan_a <= '0;
			chan_b <= '0;
			chan_c <= '0;
			chan_d <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			v = in_valid;
			if (in_valid && in_ready) begin
				deinterlace_px({chan_a, chan_b, chan_c, chan_d});
				v = 1'b0;
			end
			if (!v) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pixel_q.size() > 0) begin
					p = pixel_q.pop_front();
					chan_a <= p.a;
					chan_b <= p.b;
					chan_c <= p.c;
					chan_d <= p.d;
					v = 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 24);
						gap_left <= (tx_mode == 0) ? 0 : $urandom_range(0, tx_mode * 4);
					end else begin
						burst_left <= burst_left - 1;
					end
				end
			end
			in_valid <= v;
		end
	end

	// receiver: always ready, or stall on a periodic pattern of its own
	int rx_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_cnt <= 0;
		end else begin
			rx_cnt <= rx_cnt + 1;
			out_ready <= (rx_mode == 0) ? 1'b1 : ((rx_cnt % rx_period) < rx_duty);
		end
	end

	// check each output transaction against the oldest due pixel
	always @(posedge clk) begin
		out_px_t e;
		if (arst_n && out_valid && out_ready) begin
			if (due_q.size() == 0) begin
				report($sformatf("unexpected pixel row %0d col %0d", out_row, out_col));
			end else begin
				e = due_q.pop_front();
				if (out_a !== e.a)
					report($sformatf("out_a %0h exp %0h", out_a, e.a));
				if (out_b !== e.b)
					report($sformatf("out_b %0h exp %0h", out_b, e.b));
				if (out_c !== e.c)
					report($sformatf("out_c %0h exp %0h", out_c, e.c));
				if (out_d !== e.d)
					report($sformatf("out_d %0h exp %0h", out_d, e.d));
				if (out_row !== e.row)
					report($sformatf("out_row %0d exp %0d", out_row, e.row));
				if (out_col !== e.col)
					report($sformatf("out_col %0d exp %0d", out_col, e.col));
				if (last_of_run !== e.last)
					report($sformatf("last_of_run %0b exp %0b", last_of_run, e.last));
			end
		end
	end

	// watchdog on cycles with no transaction at all
	int idle_cyc = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
			idle_cyc <= 0;
		end else if (idle_cyc >= IDLE_LIMIT) begin
			$display("field_line_deinterlacer regression: fail");
			$finish;
		end else begin
			idle_cyc <= idle_cyc + 1;
		end
	end

	task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_PARITY: sh_parity = val[0];
			REG_WIDTH:  sh_width = val[12:0];
			REG_HEIGHT: sh_height = val[12:0];
			REG_FORMAT: sh_fmt = pix_fmt_t'(val[1:0]);
			default:    ;
		endcase
	endtask

	// wait until every pixel is sent and every output has arrived
	task automatic drain();
		while (pixel_q.size() > 0 || in_valid || due_q.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// new frame set-up, always at a frame boundary, plus new idling
	task automatic frame_setup(input int par, input int w, input int h, input pix_fmt_t f);
		drain();
		reg_write(REG_PARITY, par);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_FORMAT, f);
		tx_mode = $urandom_range(0, 3);
		rx_mode = $urandom_range(0, 2);
		rx_period = $urandom_range(2, 9);
		rx_duty = $urandom_range(1, rx_period - 1);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'hff;
			2: return 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// queue whole frames; alpha pattern forces the zero-alpha cases now and then
	task automatic queue_frames(input int nfr, input bit directed);
		pixel_t p;
		int w;
		int h;
		int am;
		w = (sh_width < 1) ? 1 : ((sh_width > LINE_DEPTH) ? LINE_DEPTH : sh_width);
		h = (sh_height < 1) ? 1 : ((sh_height > DIM_CAP) ? DIM_CAP : sh_height);
		for (int fr = 0; fr < nfr; fr++) begin
			for (int r = 0; r < h; r++) begin
				for (int c = 0; c < w; c++) begin
					p = {rand_byte(), rand_byte(), rand_byte(), rand_byte()};
					am = directed ? c % 3 : $urandom_range(0, 4);
					if (sh_fmt == FMT_GRAYA || sh_fmt == FMT_RGBA) begin
						if (am == 0)
							p[8*(3 - int'(sh_fmt)) +: 8] = 8'd0;
						else if (am == 1)
							p[8*(3 - int'(sh_fmt)) +: 8] = 8'(r % 2);
					end
					pixel_q.push_back(p);
					sent_total++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		sent_total = 0;
		sh_parity = 1'b0;
		sh_width = RST_WIDTH;
		sh_height = RST_HEIGHT;
		sh_fmt = FMT_RGB;
		tx_mode = 0;
		rx_mode = 0;
		rx_period = 2;
		rx_duty = 1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: missing first row, missing last row, zero alpha sums
		frame_setup(1, 3, 5, FMT_RGBA);
		queue_frames(1, 1'b1);
		// single missing row, zero width and zero height
		frame_setup(1, 0, 0, FMT_GRAYA);
		queue_frames(2, 1'b1);
		for (int f = 0; f < 4; f++) begin
			frame_setup(f % 2, 2, 3, pix_fmt_t'(f));
			queue_frames(1, 1'b1);
		end

		// random frames, mostly small
		while (sent_total < 1850) begin
			frame_setup($urandom_range(0, 1), $urandom_range(1, 14), $urandom_range(2, 9),
				pix_fmt_t'($urandom_range(0, 3)));
			queue_frames($urandom_range(1, 2), 1'b0);
		end

		drain();
		if (err_cnt == 0)
			$display("field_line_deinterlacer regression: pass");
		else
			$display("field_line_deinterlacer regression: fail");
		$finish;
	end

endmodule

>>> field_line_deinterlacer.f
src/fld_pkg.sv
src/fld_lane.sv
src/fld_rebuild.sv
src/field_line_deinterlacer.sv
tb/field_line_deinterlacer_tb.sv
